[src/shkt_pkg.sv]
package shkt_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned KeyW = 160;
  localparam int unsigned PosW = 10;

  typedef struct packed {
    logic        func;
    logic [31:0] key_high;
    logic [63:0] key_mid;
    logic [63:0] key_low;
    logic [31:0] result_high;
    logic [63:0] result_mid;
    logic [63:0] result_low;
  } shkt_in_t;

  typedef struct packed {
    logic        was_present;
    logic        is_converted;
    logic [31:0] out_high;
    logic [63:0] out_mid;
    logic [63:0] out_low;
    logic [9:0]  sorted_position;
    logic        table_full;
  } shkt_out_t;

  // outcome of one probe compare
  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } shkt_cmp_t;
endpackage

[src/sorted_hash_key_table.sv]
// Sorted key table: start/busy command port, one result beat per accepted
// request on out_valid, which the receiver cannot stall. A request runs a
// binary search over the sorted index (up to 11 probes, each through the
// shared key compare and the registered index and key memories), then on
// a miss, unless the table is full, shifts index entries above the insert
// point up one at a time, a read state then a write state per entry, then
// writes the slot. No clearing pass: only written slots are read.
module sorted_hash_key_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  shkt_pkg::shkt_in_t  in_data,
  output logic                out_valid,
  output shkt_pkg::shkt_out_t out_data
);
  import shkt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROBE, ST_PWAIT, ST_PCMP, ST_DECIDE, ST_SHRD, ST_SHWR,
    ST_WRITE, ST_RDH, ST_RDWAIT, ST_DONE
  } state_t;

  state_t            state_r;
  shkt_in_t          req_r;
  logic [CountW-1:0] count_r, lo_r, hi_r, mid_r, sh_r;
  logic              found_r;
  logic [AddrW-1:0]  slot_r;
  shkt_out_t         out_r;
  logic              ov_r;

  // index memory
  logic             ix_we;
  logic [AddrW-1:0] ix_waddr, ix_raddr, ix_wdata, ix_rdata;
  // key memory
  logic             k_we;
  logic [KeyW-1:0]  k_rdata;
  logic [AddrW-1:0] k_raddr;
  // hash memory with converted mark in bit 0
  logic             h_we;
  logic [KeyW:0]    h_wdata, h_rdata;

  shkt_cmp_t cmp;

  shkt_ram #(.Width(AddrW), .Depth(Capacity)) u_ix (
    .clk, .we(ix_we), .waddr(ix_waddr), .wdata(ix_wdata),
    .raddr(ix_raddr), .rdata(ix_rdata));
  shkt_ram #(.Width(KeyW), .Depth(Capacity)) u_key (
    .clk, .we(k_we), .waddr(slot_r),
    .wdata({req_r.key_high, req_r.key_mid, req_r.key_low}),
    .raddr(k_raddr), .rdata(k_rdata));
  shkt_ram #(.Width(KeyW + 1), .Depth(Capacity)) u_hash (
    .clk, .we(h_we), .waddr(slot_r), .wdata(h_wdata),
    .raddr(slot_r), .rdata(h_rdata));
  shkt_cmp u_cmp (
    .probe({req_r.key_high, req_r.key_mid, req_r.key_low}),
    .stored(k_rdata), .order(cmp));

  logic [CountW-1:0] mid_c;
  assign mid_c = CountW'((lo_r + hi_r) >> 1);

  always_comb begin
    ix_we = 1'b0;
    ix_waddr = sh_r[AddrW-1:0];
    ix_wdata = ix_rdata;
    ix_raddr = mid_c[AddrW-1:0];
    k_raddr = ix_rdata;
    k_we = 1'b0;
    h_we = 1'b0;
    h_wdata = '0;
    case (state_r)
      ST_SHRD: ix_raddr = AddrW'(sh_r - 1'b1);
      ST_SHWR: ix_we = 1'b1;
      ST_WRITE: begin
        if (!found_r) begin
          ix_we = 1'b1;
          ix_waddr = lo_r[AddrW-1:0];
          ix_wdata = slot_r;
          k_we = 1'b1;
        end
        h_we = !found_r || req_r.func;
        h_wdata = req_r.func ?
          {req_r.result_high, req_r.result_mid, req_r.result_low, 1'b1} : '0;
      end
      default: ;
    endcase
  end

  assign busy = state_r != ST_IDLE;
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r <= in_data;
            lo_r <= '0;
            hi_r <= count_r;
            found_r <= 1'b0;
            state_r <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          // search window empty: decide
          if (lo_r >= hi_r) begin
            state_r <= ST_DECIDE;
          end else begin
            mid_r <= mid_c;
            state_r <= ST_PWAIT;
          end
        end
        ST_PWAIT: state_r <= ST_PCMP;
        ST_PCMP: begin
          case (cmp)
            CMP_EQ: begin
              found_r <= 1'b1;
              lo_r <= mid_r;
              slot_r <= ix_rdata;
              state_r <= ST_DECIDE;
            end
            CMP_LT: begin
              hi_r <= mid_r;
              state_r <= ST_PROBE;
            end
            default: begin
              lo_r <= CountW'(mid_r + 1'b1);
              state_r <= ST_PROBE;
            end
          endcase
        end
        ST_DECIDE: begin
          if (found_r) begin
            state_r <= req_r.func ? ST_WRITE : ST_RDH;
          end else if (count_r >= CountW'(Capacity)) begin
            out_r <= '{was_present: 1'b0, is_converted: 1'b0, out_high: '0,
                       out_mid: '0, out_low: '0, sorted_position: PosW'(lo_r),
                       table_full: 1'b1};
            ov_r <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            slot_r <= count_r[AddrW-1:0];
            sh_r <= count_r;
            state_r <= (count_r > lo_r) ? ST_SHRD : ST_WRITE;
          end
        end
        ST_SHRD: state_r <= ST_SHWR;
        ST_SHWR: begin
          // move one index entry up, advance downward
          sh_r <= CountW'(sh_r - 1'b1);
          state_r <= (CountW'(sh_r - 1'b1) > lo_r) ? ST_SHRD : ST_WRITE;
        end
        ST_WRITE: begin
          if (!found_r) count_r <= CountW'(count_r + 1'b1);
          state_r <= ST_RDH;
        end
        ST_RDH: state_r <= ST_RDWAIT;
        ST_RDWAIT: state_r <= ST_DONE;
        ST_DONE: begin
          out_r.was_present <= found_r;
          out_r.is_converted <= h_rdata[0];
          out_r.out_high <= h_rdata[KeyW:KeyW-31];
          out_r.out_mid <= h_rdata[KeyW-32:65];
          out_r.out_low <= h_rdata[64:1];
          out_r.sorted_position <= PosW'(lo_r);
          out_r.table_full <= 1'b0;
          ov_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(Capacity)) else $error("entry count overflow");
  a_win: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> hi_r <= count_r) else $error("search window");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !busy) else $error("result while busy");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_r.table_full |-> !out_r.was_present) else $error("full hit");
`endif
endmodule

[src/shkt_ram.sv]
module shkt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/shkt_cmp.sv]
module shkt_cmp (
  input  logic [shkt_pkg::KeyW-1:0] probe,
  input  logic [shkt_pkg::KeyW-1:0] stored,
  output shkt_pkg::shkt_cmp_t       order
);
  import shkt_pkg::*;

  // big-endian byte order equals plain unsigned order of the whole word
  always_comb begin
    if (probe == stored) begin
      order = CMP_EQ;
    end else if (probe < stored) begin
      order = CMP_LT;
    end else begin
      order = CMP_GT;
    end
  end
endmodule
